// File: src/pup_pkg.sv
// ----------------------------------------------------------------------------
// pup_pkg: shared definitions of the picture unit register port
// Memory sizes, register and item codes, and the structs that pass between
// the front-end decoder and the memory pipeline.
// ----------------------------------------------------------------------------
package pup_pkg;

	localparam int PATTERN_BYTES    = 8192;
	localparam int NAME_TABLE_BYTES = 2048;
	localparam int SPRITE_BYTES     = 256;

	localparam int PAT_AW = $clog2(PATTERN_BYTES);
	localparam int NT_AW  = $clog2(NAME_TABLE_BYTES);
	localparam int SPR_AW = $clog2(SPRITE_BYTES);

	localparam logic [13:0] VADDR_NT_BASE  = 14'h2000;
	localparam logic [13:0] VADDR_PAL_BASE = 14'h3F00;
	localparam logic [7:0]  STATUS_BUSY    = 8'hC0;

	typedef enum logic [1:0] {
		KIND_REG_READ  = 2'd0,
		KIND_REG_WRITE = 2'd1,
		KIND_PAT_LOAD  = 2'd2,
		KIND_DMA_BYTE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_CTRL     = 3'd0,
		REG_MASK     = 3'd1,
		REG_STATUS   = 3'd2,
		REG_SPR_ADDR = 3'd3,
		REG_SPR_DATA = 3'd4,
		REG_SCROLL   = 3'd5,
		REG_ADDR     = 3'd6,
		REG_DATA     = 3'd7
	} reg_code_t;

	// Memory requests issued at the acceptance edge.
	typedef struct packed {
		logic              pat_rd;
		logic              pat_wr;
		logic [PAT_AW-1:0] pat_addr;
		logic              nt_rd;
		logic              nt_wr;
		logic [NT_AW-1:0]  nt_addr;
		logic              spr_rd;
		logic              spr_wr;
		logic [SPR_AW-1:0] spr_addr;
		logic [7:0]        wdata;
	} mem_req_t;

	// What the second stage needs to finish an item.
	typedef struct packed {
		logic [7:0]  rd;
		logic        rd_from_spr;
		logic        rd_from_buf;
		logic        buf_load;
		logic        buf_from_nt;
		logic        vw_valid;
		logic [13:0] vw_addr;
		logic [7:0]  vw_data;
	} item_info_t;

	// Palette index with the backdrop entries of the sprite half folded down.
	function automatic logic [4:0] pal_slot(input logic [13:0] addr);
		logic [4:0] idx;
		idx = addr[4:0];
		if (idx[4] && (idx[1:0] == 2'b00)) begin
			idx[4] = 1'b0;
		end
		return idx;
	endfunction

endpackage

// File: src/pup_decode.sv
// ----------------------------------------------------------------------------
// pup_decode: register front end of the picture unit register port
// Holds the register state and the palette, decodes each item and issues
// the memory requests and the second-stage information for it.
// ----------------------------------------------------------------------------
module pup_decode
	import pup_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [1:0]       kind,
	input  logic [2:0]       reg_req,
	input  logic [7:0]       data,
	input  logic [12:0]      load_address,
	input  logic [7:0]       dma_offset,
	output mem_req_t         mem_req,
	output item_info_t       info
);

	logic        inc32_q;
	logic [7:0]  spr_ptr_q;
	logic        toggle_q;
	logic        phase_q;
	logic [13:0] latch_q;
	logic [13:0] vaddr_q;
	logic [5:0]  pal_q [32];

	logic        inc32_d;
	logic [7:0]  spr_ptr_d;
	logic        toggle_d;
	logic        phase_d;
	logic [13:0] latch_d;
	logic [13:0] vaddr_d;
	logic        pal_wr;
	logic        is_nt;
	logic        is_pal;
	logic [13:0] vaddr_step;
	logic [4:0]  pal_idx;

	assign is_pal     = (vaddr_q >= VADDR_PAL_BASE);
	assign is_nt      = (vaddr_q >= VADDR_NT_BASE) && !is_pal;
	assign vaddr_step = vaddr_q + (inc32_q ? 14'd32 : 14'd1);
	assign pal_idx    = pal_slot(vaddr_q);

	// Mask and scroll values affect nothing the port reports, so they are not
	// kept; the read buffer lives in the second stage.
	always_comb begin
		mem_req   = '0;
		info      = '0;
		inc32_d   = inc32_q;
		spr_ptr_d = spr_ptr_q;
		toggle_d  = toggle_q;
		phase_d   = phase_q;
		latch_d   = latch_q;
		vaddr_d   = vaddr_q;
		pal_wr    = 1'b0;
		mem_req.wdata    = data;
		mem_req.pat_addr = vaddr_q[PAT_AW-1:0];
		mem_req.nt_addr  = vaddr_q[NT_AW-1:0];
		mem_req.spr_addr = spr_ptr_q;
		unique case (kind)
			KIND_REG_READ: begin
				unique case (reg_req)
					REG_STATUS: begin
						toggle_d = 1'b0;
						phase_d  = !phase_q;
						info.rd  = phase_q ? STATUS_BUSY : 8'h00;
					end
					REG_SPR_DATA: begin
						mem_req.spr_rd   = 1'b1;
						info.rd_from_spr = 1'b1;
					end
					REG_DATA: begin
						// The buffer is refilled from the name table for palette reads,
						// since the palette sits over a mirror of it.
						info.buf_load = 1'b1;
						if (is_pal) begin
							mem_req.nt_rd    = 1'b1;
							info.buf_from_nt = 1'b1;
							info.rd          = {2'b00, pal_q[pal_idx]};
						end else if (is_nt) begin
							mem_req.nt_rd    = 1'b1;
							info.buf_from_nt = 1'b1;
							info.rd_from_buf = 1'b1;
						end else begin
							mem_req.pat_rd   = 1'b1;
							info.rd_from_buf = 1'b1;
						end
						vaddr_d = vaddr_step;
					end
					default: begin
					end
				endcase
			end
			KIND_REG_WRITE: begin
				unique case (reg_req)
					REG_CTRL:     inc32_d = data[2];
					REG_SPR_ADDR: spr_ptr_d = data;
					REG_SPR_DATA: begin
						mem_req.spr_wr = 1'b1;
						spr_ptr_d      = spr_ptr_q + 8'd1;
					end
					REG_SCROLL: toggle_d = !toggle_q;
					REG_ADDR: begin
						if (!toggle_q) begin
							latch_d = {data[5:0], 8'h00};
						end else begin
							latch_d = latch_q | {6'b0, data};
							vaddr_d = latch_d;
						end
						toggle_d = !toggle_q;
					end
					REG_DATA: begin
						pal_wr         = is_pal;
						mem_req.nt_wr  = is_nt;
						info.vw_valid  = is_pal || is_nt;
						info.vw_addr   = (is_pal || is_nt) ? vaddr_q : 14'd0;
						info.vw_data   = (is_pal || is_nt) ? data : 8'h00;
						vaddr_d        = vaddr_step;
					end
					default: begin
					end
				endcase
			end
			KIND_PAT_LOAD: begin
				mem_req.pat_wr   = 1'b1;
				mem_req.pat_addr = load_address[PAT_AW-1:0];
			end
			default: begin
				mem_req.spr_wr   = 1'b1;
				mem_req.spr_addr = spr_ptr_q + dma_offset;
			end
		endcase
		if (!take) begin
			mem_req.pat_rd = 1'b0;
			mem_req.pat_wr = 1'b0;
			mem_req.nt_rd  = 1'b0;
			mem_req.nt_wr  = 1'b0;
			mem_req.spr_rd = 1'b0;
			mem_req.spr_wr = 1'b0;
			pal_wr         = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc32_q   <= 1'b0;
			spr_ptr_q <= 8'h00;
			toggle_q  <= 1'b0;
			phase_q   <= 1'b0;
			latch_q   <= 14'd0;
			vaddr_q   <= 14'd0;
			for (int i = 0; i < 32; i++) begin
				pal_q[i] <= 6'd0;
			end
		end else if (take) begin
			inc32_q   <= inc32_d;
			spr_ptr_q <= spr_ptr_d;
			toggle_q  <= toggle_d;
			phase_q   <= phase_d;
			latch_q   <= latch_d;
			vaddr_q   <= vaddr_d;
			if (pal_wr) begin
				pal_q[pal_idx] <= data[5:0];
			end
		end
	end

endmodule

// File: src/picture_unit_register_port.sv
// ----------------------------------------------------------------------------
// picture_unit_register_port: CPU-side register port of a tile video unit
// Takes register reads and writes, pattern loads and sprite DMA bytes and
// keeps the pattern, name-table, sprite and palette stores behind them.
// ----------------------------------------------------------------------------
// Path: an accepted item passes one memory read stage, then the output register.
// Throughput: one item per cycle, limited by the single read port of each
//   store, while req_stall is low; it is high during the clearing pass and
//   while the second stage is held. Stores are written at the acceptance edge.
// Reset: control state clears at once; a clearing pass then zeroes all
//   NAME_TABLE_BYTES (2048) name-table entries and the sprite memory.
// ----------------------------------------------------------------------------
module picture_unit_register_port
	import pup_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [2:0]  reg_req,
	input  logic [7:0]  data,
	input  logic [12:0] load_address,
	input  logic [7:0]  dma_offset,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  read_data,
	output logic        video_write_valid,
	output logic [13:0] video_write_address,
	output logic [7:0]  video_write_data
);

	// Stores. The pattern store is never cleared: the user must read only entries that were
	// loaded (the port does not enforce it). Name table and sprite memory are swept after reset.
	logic [7:0] pat_mem [PATTERN_BYTES];
	logic [7:0] nt_mem  [NAME_TABLE_BYTES];
	logic [7:0] spr_mem [SPRITE_BYTES];

	logic [7:0] pat_rd_q;
	logic [7:0] nt_rd_q;
	logic [7:0] spr_rd_q;

	logic             clr_busy_q;
	logic [NT_AW-1:0] clr_addr_q;

	logic        take;
	logic        advance;
	mem_req_t    mem_req;
	item_info_t  info;

	logic        valid_s1;
	item_info_t  item_s1;
	logic [7:0]  buf_q;
	logic [7:0]  rd_s1;

	logic        nt_we;
	logic [NT_AW-1:0]  nt_waddr;
	logic [7:0]  nt_wdata;
	logic        spr_we;
	logic [SPR_AW-1:0] spr_waddr;
	logic [7:0]  spr_wdata;

	// The first stage stalls only while the sweep runs or while the second
	// stage holds an item that cannot move into the output register.
	assign advance   = valid_s1 && (!rsp_valid || !rsp_stall);
	assign req_stall = clr_busy_q || (valid_s1 && !advance);
	assign take      = req_valid && !req_stall;

	pup_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.kind         (kind),
		.reg_req      (reg_req),
		.data         (data),
		.load_address (load_address),
		.dma_offset   (dma_offset),
		.mem_req      (mem_req),
		.info         (info)
	);

	// Clearing pass: one name-table entry per cycle; the sprite memory is
	// covered by the low address bits during the same sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == NT_AW'(NAME_TABLE_BYTES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign nt_we     = clr_busy_q || mem_req.nt_wr;
	assign nt_waddr  = clr_busy_q ? clr_addr_q : mem_req.nt_addr;
	assign nt_wdata  = clr_busy_q ? 8'h00 : mem_req.wdata;
	assign spr_we    = clr_busy_q || mem_req.spr_wr;
	assign spr_waddr = clr_busy_q ? clr_addr_q[SPR_AW-1:0] : mem_req.spr_addr;
	assign spr_wdata = clr_busy_q ? 8'h00 : mem_req.wdata;

	// Each item either reads or writes a given store, so a read never meets
	// a write to the same entry at one edge. A write lands before any later
	// item's read, and the read registers hold while the second stage waits
	// because no new item is taken then.
	always_ff @(posedge clk) begin
		if (mem_req.pat_wr) begin
			pat_mem[mem_req.pat_addr] <= mem_req.wdata;
		end
		if (mem_req.pat_rd) begin
			pat_rd_q <= pat_mem[mem_req.pat_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (nt_we) begin
			nt_mem[nt_waddr] <= nt_wdata;
		end
		if (mem_req.nt_rd) begin
			nt_rd_q <= nt_mem[mem_req.nt_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (spr_we) begin
			spr_mem[spr_waddr] <= spr_wdata;
		end
		if (mem_req.spr_rd) begin
			spr_rd_q <= spr_mem[mem_req.spr_addr];
		end
	end

	// Second stage: the read data arrives and the buffered data read is
	// finished. The buffer is updated in item order, so each data read outside
	// the palette returns what the previous data read fetched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= 8'h00;
		end else if (advance && item_s1.buf_load) begin
			buf_q <= item_s1.buf_from_nt ? nt_rd_q : pat_rd_q;
		end
	end

	always_comb begin
		if (item_s1.rd_from_spr) begin
			rd_s1 = spr_rd_q;
		end else if (item_s1.rd_from_buf) begin
			rd_s1 = buf_q;
		end else begin
			rd_s1 = item_s1.rd;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data           <= rd_s1;
			video_write_valid   <= item_s1.vw_valid;
			video_write_address <= item_s1.vw_addr;
			video_write_data    <= item_s1.vw_data;
		end
	end

endmodule

// File: src/pup_checker.sv
// ----------------------------------------------------------------------------
// pup_checker: port-level checks of the picture unit register port
// Watches the top-level ports only and is attached by a bind statement.
// ----------------------------------------------------------------------------
module pup_checker
	import pup_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [7:0]  read_data,
	input logic        video_write_valid,
	input logic [13:0] video_write_address,
	input logic [7:0]  video_write_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result item dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(read_data) && $stable(video_write_address))
		else $error("stalled result item changed");

	a_vw_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && video_write_valid |-> video_write_address >= VADDR_NT_BASE
		&& read_data == 8'h00)
		else $error("video write outside name table and palette");

	a_vw_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !video_write_valid |-> video_write_address == 14'd0
		&& video_write_data == 8'h00)
		else $error("video write fields set without a video write");

	a_sweep: assert property (@(posedge clk)
		$rose(arst_n) |-> req_stall && !rsp_valid)
		else $error("item taken before the clearing pass");

endmodule

bind picture_unit_register_port pup_checker u_pup_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_stall           (req_stall),
	.rsp_valid           (rsp_valid),
	.rsp_stall           (rsp_stall),
	.read_data           (read_data),
	.video_write_valid   (video_write_valid),
	.video_write_address (video_write_address),
	.video_write_data    (video_write_data)
);

// File: tb/sv/picture_unit_register_port_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picture_unit_register_port_tb: self-checking bench of the register port
// Drives register reads and writes, pattern loads and sprite DMA bytes into
// the port, predicts results from a shadow copy of the port's state, and
// compares each result with the oldest expectation. Both sides idle at random.
// ----------------------------------------------------------------------------
module picture_unit_register_port_tb;
	import pup_pkg::*;

	localparam int      DIRECTED_ROWS    = 24;
	localparam int      RANDOM_ITEMS     = 1200;
	localparam int      LONG_HOLD_CYCLES = 300;
	localparam int      DRAIN_CYCLES     = 8;
	localparam int      REPORT_LIMIT     = 10;
	localparam longint  WATCHDOG_NS      = 8_000_000;

	// One bus access as it is offered on the request side.
	typedef struct packed {
		kind_t       kind;
		reg_code_t   reg_sel;
		logic [7:0]  data;
		logic [12:0] load_address;
		logic [7:0]  dma_offset;
	} bus_item_t;

	// One result as it leaves the response side.
	typedef struct packed {
		logic [7:0]  rd;
		logic        vw_valid;
		logic [13:0] vw_addr;
		logic [7:0]  vw_data;
	} port_result_t;

	// A row of the directed table; when typed is set, the result is given here.
	typedef struct {
		kind_t       kind;
		reg_code_t   reg_sel;
		logic [7:0]  data;
		logic [12:0] load_address;
		logic [7:0]  dma_offset;
		bit          typed;
		logic [7:0]  rd;
		bit          vw_valid;
		logic [13:0] vw_addr;
		logic [7:0]  vw_data;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  kind;
	logic [2:0]  reg_req;
	logic [7:0]  data;
	logic [12:0] load_address;
	logic [7:0]  dma_offset;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [7:0]  read_data;
	logic        video_write_valid;
	logic [13:0] video_write_address;
	logic [7:0]  video_write_data;

	picture_unit_register_port u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.req_valid          (req_valid),
		.req_stall          (req_stall),
		.kind               (kind),
		.reg_req            (reg_req),
		.data               (data),
		.load_address       (load_address),
		.dma_offset         (dma_offset),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.read_data          (read_data),
		.video_write_valid  (video_write_valid),
		.video_write_address(video_write_address),
		.video_write_data   (video_write_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Shadow state of the port. Everything is zero after reset, which is what
	// the bit type starts at. The pattern store is tracked entry by entry so
	// that the bench never reads a pattern byte that was never loaded.
	// ------------------------------------------------------------------------
	bit [7:0]  shadow_ctrl;
	bit [7:0]  shadow_mask;
	bit [7:0]  shadow_spr_ptr;
	bit [7:0]  shadow_spr_mem [SPRITE_BYTES];
	bit        shadow_toggle;
	bit        shadow_phase;
	bit [7:0]  shadow_scroll_x;
	bit [7:0]  shadow_scroll_y;
	bit [13:0] shadow_latch;
	bit [13:0] shadow_vaddr;
	bit [7:0]  shadow_rdbuf;
	bit [7:0]  shadow_nt [NAME_TABLE_BYTES];
	bit [5:0]  shadow_pal [32];
	bit [7:0]  shadow_pat [PATTERN_BYTES];
	bit        pat_loaded [PATTERN_BYTES];

	port_result_t pending_results [$];
	bus_item_t    stim_q [$];
	int           mismatch_count;
	int           burst_left;
	bit           hold_off_pending;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		// Status answers alternate 0 and 0xC0, starting with 0 after reset.
		'{KIND_REG_READ,  REG_STATUS,   8'h00, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_READ,  REG_STATUS,   8'hFF, 13'h1FFF, 8'hFF, 1, 8'hC0, 0, 14'h0000, 8'h00},
		'{KIND_REG_READ,  REG_SPR_DATA, 8'h00, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		// A status write is ignored.
		'{KIND_REG_WRITE, REG_STATUS,   8'hFF, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_WRITE, REG_MASK,     8'hFF, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		// The sprite pointer wraps from 0xFF to 0 after a sprite data write.
		'{KIND_REG_WRITE, REG_SPR_ADDR, 8'hFF, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_WRITE, REG_SPR_DATA, 8'hA5, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		// A DMA byte at offset 0xFF from pointer 0 lands on the last entry.
		'{KIND_DMA_BYTE,  REG_DATA,     8'h5A, 13'h1FFF, 8'hFF, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_WRITE, REG_SPR_ADDR, 8'hFF, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_READ,  REG_SPR_DATA, 8'h00, 13'h0000, 8'h00, 0, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_PAT_LOAD,  REG_CTRL,     8'hFF, 13'h1FFF, 8'hFF, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_PAT_LOAD,  REG_CTRL,     8'h81, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_WRITE, REG_SCROLL,   8'h00, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_WRITE, REG_SCROLL,   8'hFF, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		// Address 0x3FFF: the top palette entry, then the address wraps to 0.
		'{KIND_REG_WRITE, REG_ADDR,     8'hFF, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_WRITE, REG_ADDR,     8'hFF, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_WRITE, REG_DATA,     8'hFF, 13'h0000, 8'h00, 1, 8'h00, 1, 14'h3FFF, 8'hFF},
		// The first buffered read answers the empty buffer.
		'{KIND_REG_READ,  REG_DATA,     8'h00, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		// A data write into pattern space is neither stored nor reported.
		'{KIND_REG_WRITE, REG_DATA,     8'h33, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		// Step by 32 from the top of the name table into the palette.
		'{KIND_REG_WRITE, REG_CTRL,     8'h04, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_WRITE, REG_ADDR,     8'h3E, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_WRITE, REG_ADDR,     8'hFF, 13'h0000, 8'h00, 1, 8'h00, 0, 14'h0000, 8'h00},
		'{KIND_REG_WRITE, REG_DATA,     8'h00, 13'h0000, 8'h00, 1, 8'h00, 1, 14'h3EFF, 8'h00},
		// Palette reads are not buffered.
		'{KIND_REG_READ,  REG_DATA,     8'h00, 13'h0000, 8'h00, 0, 8'h00, 0, 14'h0000, 8'h00}
	};

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic int nt_index(input logic [13:0] a);
		return int'(a[11:0]) % NAME_TABLE_BYTES;
	endfunction

	// The backdrop entries of the sprite half share storage with the
	// background half.
	function automatic int pal_index(input logic [13:0] a);
		logic [4:0] idx;
		idx = a[4:0];
		if ((idx & 5'h13) == 5'h10)
			idx = idx & 5'h0F;
		return int'(idx);
	endfunction

	function automatic logic [7:0] video_byte(input logic [13:0] a);
		if (a < VADDR_NT_BASE)
			return shadow_pat[a[PAT_AW-1:0]];
		if (a < VADDR_PAL_BASE)
			return shadow_nt[nt_index(a)];
		return {2'b00, shadow_pal[pal_index(a)]};
	endfunction

	function automatic void advance_vaddr();
		shadow_vaddr = shadow_vaddr + (shadow_ctrl[2] ? 14'd32 : 14'd1);
	endfunction

	// Applies one accepted item to the shadow state and returns its result.
	function automatic port_result_t apply_bus_access(input bus_item_t x);
		port_result_t r;
		r = '0;
		case (x.kind)
			KIND_REG_READ: begin
				case (x.reg_sel)
					REG_STATUS: begin
						shadow_toggle = 1'b0;
						shadow_phase  = ~shadow_phase;
						r.rd = shadow_phase ? 8'h00 : STATUS_BUSY;
					end
					REG_SPR_DATA: r.rd = shadow_spr_mem[shadow_spr_ptr];
					REG_DATA: begin
						if (shadow_vaddr >= VADDR_PAL_BASE) begin
							r.rd = video_byte(shadow_vaddr);
							shadow_rdbuf = video_byte(shadow_vaddr - 14'h1000);
						end else begin
							r.rd = shadow_rdbuf;
							shadow_rdbuf = video_byte(shadow_vaddr);
						end
						advance_vaddr();
					end
					default: ;
				endcase
			end
			KIND_REG_WRITE: begin
				case (x.reg_sel)
					REG_CTRL:     shadow_ctrl = x.data;
					REG_MASK:     shadow_mask = x.data;
					REG_SPR_ADDR: shadow_spr_ptr = x.data;
					REG_SPR_DATA: begin
						shadow_spr_mem[shadow_spr_ptr] = x.data;
						shadow_spr_ptr = shadow_spr_ptr + 8'd1;
					end
					REG_SCROLL: begin
						if (!shadow_toggle)
							shadow_scroll_x = x.data;
						else
							shadow_scroll_y = x.data;
						shadow_toggle = ~shadow_toggle;
					end
					REG_ADDR: begin
						if (!shadow_toggle) begin
							shadow_latch = {x.data[5:0], 8'h00};
						end else begin
							shadow_latch = shadow_latch | {6'b0, x.data};
							shadow_vaddr = shadow_latch;
						end
						shadow_toggle = ~shadow_toggle;
					end
					REG_DATA: begin
						if (shadow_vaddr >= VADDR_PAL_BASE)
							shadow_pal[pal_index(shadow_vaddr)] = x.data[5:0];
						else if (shadow_vaddr >= VADDR_NT_BASE)
							shadow_nt[nt_index(shadow_vaddr)] = x.data;
						if (shadow_vaddr >= VADDR_NT_BASE) begin
							r.vw_valid = 1'b1;
							r.vw_addr  = shadow_vaddr;
							r.vw_data  = x.data;
						end
						advance_vaddr();
					end
					default: ;
				endcase
			end
			KIND_PAT_LOAD: begin
				shadow_pat[x.load_address] = x.data;
				pat_loaded[x.load_address] = 1'b1;
			end
			default: shadow_spr_mem[shadow_spr_ptr + x.dma_offset] = x.data;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [7:0] rand8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic bus_item_t make_item(input kind_t k, input reg_code_t r,
		input logic [7:0] d);
		bus_item_t it;
		it.kind         = k;
		it.reg_sel      = r;
		it.data         = d;
		it.load_address = 13'($urandom_range(0, PATTERN_BYTES - 1));
		it.dma_offset   = rand8();
		return it;
	endfunction

	// Reads of registers without a read side and status writes change nothing.
	function automatic bit is_ignored(input bus_item_t it);
		if (it.kind == KIND_REG_READ)
			return !(it.reg_sel == REG_STATUS || it.reg_sel == REG_SPR_DATA ||
				it.reg_sel == REG_DATA);
		return it.kind == KIND_REG_WRITE && it.reg_sel == REG_STATUS;
	endfunction

	// Hot windows keep written bytes likely to be read back.
	function automatic logic [12:0] pick_pattern_address();
		if ($urandom_range(0, 3) == 0)
			return 13'($urandom_range(0, PATTERN_BYTES - 1));
		return 13'($urandom_range(0, 63)) | ($urandom_range(0, 1) ? 13'h1FC0 : 13'h0000);
	endfunction

	function automatic logic [13:0] pick_video_target();
		int zone;
		zone = $urandom_range(0, 7);
		if (zone < 2)
			return 14'($urandom_range(16'h2000, 16'h3EFF));
		if (zone < 4)
			return 14'h2000 | (14'($urandom_range(0, 1)) << 12) |
				(14'($urandom_range(0, 1)) << 11) | 14'($urandom_range(0, 63));
		if (zone < 6)
			return 14'($urandom_range(16'h3F00, 16'h3FFF));
		return {1'b0, pick_pattern_address()};
	endfunction

	task automatic aim_video_address(input logic [13:0] target);
		stim_q.push_back(make_item(KIND_REG_READ, REG_STATUS, rand8()));
		stim_q.push_back(make_item(KIND_REG_WRITE, REG_ADDR,
			{2'($urandom_range(0, 3)), target[13:8]}));
		stim_q.push_back(make_item(KIND_REG_WRITE, REG_ADDR, target[7:0]));
	endtask

	// Queues one short sequence. Most are well formed with random content; a
	// share is broken (a lone address write) or plain noise.
	task automatic queue_random_sequence();
		int          pick;
		int          n;
		int          k;
		int          burst_kind;
		logic [13:0] target;
		logic [7:0]  start;
		bus_item_t   it;
		pick = $urandom_range(0, 99);
		n    = $urandom_range(1, 12);
		if (pick < 35) begin
			if ($urandom_range(0, 3) == 0)
				stim_q.push_back(make_item(KIND_REG_WRITE, REG_CTRL, rand8()));
			target = pick_video_target();
			aim_video_address(target);
			burst_kind = $urandom_range(0, 2);
			for (k = 0; k < n; k++) begin
				if (burst_kind == 0 || (burst_kind == 2 && $urandom_range(0, 1)))
					stim_q.push_back(make_item(KIND_REG_WRITE, REG_DATA, rand8()));
				else
					stim_q.push_back(make_item(KIND_REG_READ, REG_DATA, rand8()));
			end
			// Read a written run back; one extra read drains the buffer.
			if (burst_kind == 0 && $urandom_range(0, 1)) begin
				aim_video_address(target);
				for (k = 0; k <= n; k++)
					stim_q.push_back(make_item(KIND_REG_READ, REG_DATA, rand8()));
			end
		end else if (pick < 50) begin
			start = $urandom_range(0, 1) ? rand8() : 8'($urandom_range(0, 15));
			stim_q.push_back(make_item(KIND_REG_WRITE, REG_SPR_ADDR, start));
			for (k = 0; k < n; k++) begin
				case ($urandom_range(0, 4))
					0, 1:    it = make_item(KIND_REG_WRITE, REG_SPR_DATA, rand8());
					2, 3:    it = make_item(KIND_REG_READ, REG_SPR_DATA, rand8());
					default: it = make_item(KIND_DMA_BYTE, reg_code_t'($urandom_range(0, 7)),
						rand8());
				endcase
				stim_q.push_back(it);
			end
		end else if (pick < 60) begin
			start = rand8();
			for (k = 0; k < n; k++) begin
				it = make_item(KIND_DMA_BYTE, reg_code_t'($urandom_range(0, 7)), rand8());
				it.dma_offset = start + 8'(k);
				stim_q.push_back(it);
			end
		end else if (pick < 70) begin
			for (k = 0; k < n; k++) begin
				it = make_item(KIND_PAT_LOAD, reg_code_t'($urandom_range(0, 7)), rand8());
				it.load_address = pick_pattern_address();
				stim_q.push_back(it);
			end
		end else if (pick < 80) begin
			stim_q.push_back(make_item(KIND_REG_WRITE, REG_CTRL, rand8()));
			stim_q.push_back(make_item(KIND_REG_WRITE, REG_MASK, rand8()));
			repeat ($urandom_range(1, 2))
				stim_q.push_back(make_item(KIND_REG_WRITE, REG_SCROLL, rand8()));
		end else if (pick < 88) begin
			if ($urandom_range(0, 1))
				stim_q.push_back(make_item(KIND_REG_WRITE, REG_ADDR, rand8()));
			repeat ($urandom_range(1, 3))
				stim_q.push_back(make_item(KIND_REG_READ, REG_STATUS, rand8()));
		end else begin
			repeat ($urandom_range(1, 4)) begin
				it = make_item(kind_t'($urandom_range(0, 3)),
					reg_code_t'($urandom_range(0, 7)), rand8());
				stim_q.push_back(it);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Request side. Fields change at the falling edge; the item is taken at
	// the first rising edge with req_stall low. The item is predicted at that
	// edge, so the shadow state always matches what the port has accepted.
	// ------------------------------------------------------------------------
	task automatic send_item(input bus_item_t it, input bit typed, input port_result_t want);
		bus_item_t    x;
		port_result_t predicted;
		int           gap;
		x = it;
		// A data read in pattern space must find a loaded byte; otherwise the
		// item becomes a load of that very byte.
		if (x.kind == KIND_REG_READ && x.reg_sel == REG_DATA &&
			shadow_vaddr < VADDR_NT_BASE && !pat_loaded[shadow_vaddr[PAT_AW-1:0]]) begin
			x.kind         = KIND_PAT_LOAD;
			x.load_address = shadow_vaddr[PAT_AW-1:0];
		end
		@(negedge clk);
		kind         <= x.kind;
		reg_req      <= x.reg_sel;
		data         <= x.data;
		load_address <= x.load_address;
		dma_offset   <= x.dma_offset;
		req_valid    <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = apply_bus_access(x);
		pending_results.push_back(typed ? want : predicted);
		// Bursts of back-to-back items separated by random gaps.
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1)
					@(negedge clk);
			end
		end
	endtask

	initial begin : stimulus
		int            k;
		int            counted;
		bit            drained_mid_run;
		bus_item_t     it;
		port_result_t  want;
		directed_row_t row;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		kind         = KIND_REG_READ;
		reg_req      = REG_CTRL;
		data         = 8'h00;
		load_address = 13'h0000;
		dma_offset   = 8'h00;
		burst_left   = 1;
		counted      = 0;
		drained_mid_run = 1'b0;
		repeat (12)
			@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. The port clears its stores after reset with
		// req_stall high, so the first item simply waits for that.
		for (k = 0; k < DIRECTED_ROWS; k++) begin
			row = directed_rows[k];
			it.kind         = row.kind;
			it.reg_sel      = row.reg_sel;
			it.data         = row.data;
			it.load_address = row.load_address;
			it.dma_offset   = row.dma_offset;
			want.rd         = row.rd;
			want.vw_valid   = row.vw_valid;
			want.vw_addr    = row.vw_addr;
			want.vw_data    = row.vw_data;
			send_item(it, row.typed, want);
		end

		// The response side starts its long hold-off while items keep coming.
		hold_off_pending = 1'b1;
		while (counted < RANDOM_ITEMS) begin
			// Once, halfway, let every outstanding result drain before going on.
			if (!drained_mid_run && counted >= RANDOM_ITEMS / 2) begin
				drained_mid_run = 1'b1;
				@(negedge clk);
				req_valid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			if (stim_q.size() == 0)
				queue_random_sequence();
			it = stim_q.pop_front();
			if (!is_ignored(it))
				counted++;
			send_item(it, 1'b0, '0);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Response side: stretches of random stall density, some with none at
	// all, and one long hold-off that backs the port up into its input.
	// ------------------------------------------------------------------------
	initial begin : rsp_stall_pattern
		int mode;
		int run;
		int k;
		rsp_stall = 1'b0;
		forever begin
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				for (k = 0; k < LONG_HOLD_CYCLES; k++) begin
					@(negedge clk);
					rsp_stall <= 1'b1;
				end
			end
			mode = $urandom_range(0, 3);
			run  = $urandom_range(8, 64);
			repeat (run) begin
				@(negedge clk);
				case (mode)
					0:       rsp_stall <= 1'b0;
					1:       rsp_stall <= ($urandom_range(0, 3) == 0);
					2:       rsp_stall <= 1'($urandom_range(0, 1));
					default: rsp_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------
	task automatic note_mismatch(input string what, input port_result_t want,
		input port_result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s: read_data %h/%h write_valid %b/%b address %h/%h data %h/%h",
				$realtime, what, want.rd, got.rd, want.vw_valid, got.vw_valid,
				want.vw_addr, got.vw_addr, want.vw_data, got.vw_data);
	endtask

	always @(posedge clk) begin
		port_result_t got;
		port_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got.rd       = read_data;
			got.vw_valid = video_write_valid;
			got.vw_addr  = video_write_address;
			got.vw_data  = video_write_data;
			if (pending_results.size() == 0) begin
				note_mismatch("result with nothing expected (expected/actual)", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.rd !== want.rd || got.vw_valid !== want.vw_valid ||
					got.vw_addr !== want.vw_addr || got.vw_data !== want.vw_data)
					note_mismatch("result mismatch (expected/actual)", want, got);
			end
		end
	end

	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
src/pup_pkg.sv
src/pup_decode.sv
src/picture_unit_register_port.sv
src/pup_checker.sv
tb/sv/picture_unit_register_port_tb.sv
